// ===== rtl/cartridge_rom_address_mapper_macros.svh =====
// ----------------------------------------------------------------------------
// Cartridge ROM address mapper: assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef CARTRIDGE_ROM_ADDRESS_MAPPER_MACROS_SVH
`define CARTRIDGE_ROM_ADDRESS_MAPPER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CRM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CRM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/crm_pkg.sv =====
// ----------------------------------------------------------------------------
// Cartridge ROM address mapper package
// Item types, configuration record, register indexes and mapping constants.
// ----------------------------------------------------------------------------
package crm_pkg;

    localparam int ADDR_W  = 24;
    localparam int UNITS_W = 9;
    localparam int LIMIT_W = ADDR_W + 1;

    // Configuration register indexes
    localparam logic [1:0] CFG_MAP_TYPE       = 2'd0;
    localparam logic [1:0] CFG_ROM_SIZE_UNITS = 2'd1;
    localparam logic [1:0] CFG_HEADER_PRESENT = 2'd2;

    // Mapping types: paged is the LoROM layout, flat the HiROM layout
    localparam logic [1:0] MAP_PAGED = 2'd0;
    localparam logic [1:0] MAP_FLAT  = 2'd1;
    localparam logic [1:0] MAP_NONE  = 2'd2;

    // Opcodes
    localparam logic OP_BUS_TO_FILE = 1'b0;
    localparam logic OP_FILE_TO_BUS = 1'b1;

    // Extended layouts start once the ROM exceeds this many 32 KiB units
    localparam logic [UNITS_W-1:0] EXT_UNITS = 9'd128;

    localparam logic [LIMIT_W-1:0] HDR_BYTES = 25'h000_0200;
    localparam logic [LIMIT_W-1:0] EXT_BASE  = 25'h040_0000;

    typedef struct packed {
        logic              opcode;
        logic [ADDR_W-1:0] address_in;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] address_out;
        logic              error;
    } out_item_t;

    typedef struct packed {
        logic [1:0]         map_type;
        logic [UNITS_W-1:0] rom_size_units;
        logic               header_present;
    } cfg_t;

endpackage

// ===== rtl/crm_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Cartridge ROM address mapper: configuration registers
// Holds map type, ROM size and header flag written through the write port.
// ----------------------------------------------------------------------------
module crm_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_addr,
    input  logic [crm_pkg::UNITS_W-1:0]   cfg_wdata,
    output crm_pkg::cfg_t                 cfg
);

    crm_pkg::cfg_t cfg_reg;
    crm_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_addr)
                crm_pkg::CFG_MAP_TYPE:       cfg_next.map_type       = cfg_wdata[1:0];
                crm_pkg::CFG_ROM_SIZE_UNITS: cfg_next.rom_size_units = cfg_wdata;
                crm_pkg::CFG_HEADER_PRESENT: cfg_next.header_present = cfg_wdata[0];
                default:                     cfg_next = cfg_reg; // drop unknown index
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.map_type       <= crm_pkg::MAP_NONE;
            cfg_reg.rom_size_units <= '0;
            cfg_reg.header_present <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/crm_xlate.sv =====
// ----------------------------------------------------------------------------
// Cartridge ROM address mapper: translation logic
// Combinational bus-to-file and file-to-bus mapping with range checks.
// ----------------------------------------------------------------------------
module crm_xlate (
    input  crm_pkg::cfg_t      cfg,
    input  crm_pkg::in_item_t  item_in,
    output crm_pkg::out_item_t item_out
);

    logic [7:0]                  bank;
    logic                        ext;
    logic [crm_pkg::LIMIT_W-1:0] hdr;
    logic [crm_pkg::LIMIT_W-1:0] limit;
    logic [crm_pkg::LIMIT_W-1:0] b2f_off;
    logic                        b2f_err;
    logic [crm_pkg::ADDR_W-1:0]  f2b_rel;
    logic [crm_pkg::ADDR_W-1:0]  f2b_ext;
    logic [crm_pkg::ADDR_W-1:0]  f2b_addr;
    logic                        f2b_err;

    assign bank  = item_in.address_in[23:16];
    assign ext   = cfg.rom_size_units > crm_pkg::EXT_UNITS;
    assign hdr   = cfg.header_present ? crm_pkg::HDR_BYTES : '0;
    assign limit = {1'b0, cfg.rom_size_units, 15'd0} + hdr;

    // Bus address to file offset
    always_comb begin
        b2f_off = '0;
        b2f_err = 1'b0;
        case (cfg.map_type)
            crm_pkg::MAP_PAGED: begin
                if (!item_in.address_in[15]) begin
                    b2f_err = 1'b1;
                end else if (ext && bank <= 8'h7D) begin
                    b2f_off = {2'b00, bank, item_in.address_in[14:0]}
                              + crm_pkg::EXT_BASE + hdr;
                end else if (bank inside {[8'h70:8'h7F]}) begin
                    b2f_err = 1'b1;
                end else begin
                    b2f_off = {3'b000, bank[6:0], item_in.address_in[14:0]} + hdr;
                end
            end
            crm_pkg::MAP_FLAT: begin
                if (bank <= 8'h77 && !item_in.address_in[15]) begin
                    b2f_err = 1'b1;
                end else if (bank inside {8'h7E, 8'h7F}) begin
                    b2f_err = 1'b1;
                end else begin
                    b2f_off = {3'b000, item_in.address_in[21:0]} + hdr
                              + ((ext && bank < 8'hC0) ? crm_pkg::EXT_BASE : '0);
                end
            end
            default: b2f_err = 1'b1;
        endcase
        if (b2f_off >= limit) begin
            b2f_err = 1'b1;
        end
    end

    // File offset to bus address
    assign f2b_rel = item_in.address_in - hdr[crm_pkg::ADDR_W-1:0];
    assign f2b_ext = f2b_rel - crm_pkg::EXT_BASE[crm_pkg::ADDR_W-1:0];

    always_comb begin
        f2b_addr = '0;
        f2b_err  = 1'b0;
        if ({1'b0, item_in.address_in} >= limit) begin
            f2b_err = 1'b1;
        end else if (cfg.map_type != crm_pkg::MAP_PAGED
                     && cfg.map_type != crm_pkg::MAP_FLAT) begin
            f2b_err = 1'b1;
        end else if ({1'b0, item_in.address_in} < hdr) begin
            f2b_err = 1'b1; // offset falls inside the copier header
        end else if (cfg.map_type == crm_pkg::MAP_PAGED) begin
            if (ext && f2b_rel[23:22] != 2'b00) begin
                f2b_addr = {1'b0, f2b_ext[21:15], 1'b1, f2b_rel[14:0]};
            end else begin
                f2b_addr = {1'b1, f2b_rel[21:15], 1'b1, f2b_rel[14:0]};
            end
        end else begin
            if (ext && f2b_rel[23:22] != 2'b00) begin
                if (f2b_rel >= 24'h70_0000 && f2b_rel <= 24'h78_0000 && !f2b_rel[15]) begin
                    f2b_err = 1'b1;
                end else begin
                    f2b_addr = f2b_rel;
                end
            end else begin
                f2b_addr = {2'b11, f2b_rel[21:0]};
            end
        end
    end

    always_comb begin
        if (item_in.opcode == crm_pkg::OP_FILE_TO_BUS) begin
            item_out.error       = f2b_err;
            item_out.address_out = f2b_err ? '0 : f2b_addr;
        end else begin
            item_out.error       = b2f_err;
            item_out.address_out = b2f_err ? '0 : b2f_off[crm_pkg::ADDR_W-1:0];
        end
    end

endmodule

// ===== rtl/cartridge_rom_address_mapper.sv =====
// ----------------------------------------------------------------------------
// Cartridge ROM address mapper
// Two-register pipeline translating console bus addresses and image offsets.
// ----------------------------------------------------------------------------
// Each item carries an opcode and a 24-bit address. Opcode 0 turns a
// bank:offset console bus address into a byte offset in the ROM image file
// (copier header included); opcode 1 turns an image offset back into a bus
// address. LoROM and HiROM layouts are supported, with the extended
// variants once the ROM is larger than 4 MiB. Any invalid bank or offset, a
// file offset at or past the image end, an offset inside the copier header, or
// an unidentified map type gives error = 1 with address_out = 0. The block
// takes one item per cycle while the result side drains; each item is held
// in the input register, passes the translation logic and is captured in
// the result register. Ready on the input side stays high as long as the
// result side keeps draining. Write the configuration registers only while
// no item is in flight.
module cartridge_rom_address_mapper (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration write port
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_addr,
    input  logic [crm_pkg::UNITS_W-1:0] cfg_wdata,
    // input items
    input  logic                        s_valid,
    output logic                        s_ready,
    input  crm_pkg::in_item_t           s_data,
    // result items
    output logic                        m_valid,
    input  logic                        m_ready,
    output crm_pkg::out_item_t          m_data
);

    crm_pkg::cfg_t      cfg;
    crm_pkg::out_item_t xlate_out;

    logic               in_valid_reg;
    logic               in_valid_next;
    crm_pkg::in_item_t  in_item_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    crm_pkg::out_item_t out_item_reg;

    logic               out_load;
    logic               in_load;

    crm_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    crm_xlate u_xlate (
        .cfg      (cfg),
        .item_in  (in_item_reg),
        .item_out (xlate_out)
    );

    // Advance the input stage into the result register whenever the result
    // register is empty or being taken this cycle.
    assign out_load = in_valid_reg && (!out_valid_reg || m_ready);
    // Take a new item when the input stage is empty or moving on.
    assign s_ready  = !in_valid_reg || out_load;
    assign in_load  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_load) begin
            in_valid_next = 1'b1;
        end else if (out_load) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0; // drop the delivered item
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load only on a move, hold otherwise
    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_item_reg <= s_data;
        end
        if (out_load) begin
            out_item_reg <= xlate_out;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

endmodule

// ===== rtl/crm_port_checker.sv =====
// ----------------------------------------------------------------------------
// Cartridge ROM address mapper: port checker
// Concurrent assertions on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "cartridge_rom_address_mapper_macros.svh"

module crm_port_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input crm_pkg::out_item_t m_data
);

    // An errored result never carries an address
    `CRM_ASSERT_NOW(a_err_zero, aclk, aresetn, m_valid && m_data.error, m_data.address_out == '0, "error result with nonzero address")

    // A stalled result holds its value
    `CRM_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "stalled result changed or vanished")

    // A result rises only where an accepted item has passed through the input register
    `CRM_ASSERT_NOW(a_no_invent, aclk, aresetn, $rose(m_valid), $past(s_valid && s_ready, 2), "result without accepted item")

    // With the result side draining, input is never refused
    `CRM_ASSERT_NOW(a_flow, aclk, aresetn, m_ready, s_ready, "input stalled while output drains")

endmodule

bind cartridge_rom_address_mapper crm_port_checker u_port_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
